// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file of the keypad code lock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("keypad code lock check failed");

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  `ASSERT_CLK(label, clk, rst_n, (pre) |-> (post))

`endif

// ----- hw/rtl/kcl_pkg.sv -----
// Types, constants and event codes of the keypad code lock.
`default_nettype none
package kcl_pkg;

  localparam int unsigned ENTRY_LEN_DEF   = 8;
  localparam int unsigned TABLE_DEPTH_DEF = 16;

  localparam int unsigned CODE_W = 64;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned CHAR_W = 8;

  localparam logic [CODE_W-1:0] MASTER_CODE_RESET = 64'h3939_3939_3939_3939;
  localparam logic [LEN_W-1:0]  MASTER_LEN_RESET  = 4'd8;
  localparam logic [CODE_W-1:0] STAR_CODE         = 64'h0000_0000_002A_2A2A;
  localparam logic [LEN_W-1:0]  STAR_LEN          = 4'd3;

  // Register select is address bit 3: registers lie 8 bytes apart.
  localparam logic REG_MASTER_CODE = 1'b0;
  localparam logic REG_MASTER_LEN  = 1'b1;

  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_MASTER  = 3'd1,
    EV_ONETIME = 3'd2,
    EV_LOCKED  = 3'd3,
    EV_STORED  = 3'd4,
    EV_FULL    = 3'd5
  } event_e;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } otc_entry_t;

  typedef struct packed {
    logic       en;
    otc_entry_t data;
  } otc_wr_t;

endpackage
`default_nettype wire

// ----- hw/rtl/kcl_match.sv -----
// Shared compare unit: does a code of given length equal the current entry.
`default_nettype none
module kcl_match (
  input  logic [kcl_pkg::CODE_W-1:0] code_i,
  input  logic [kcl_pkg::LEN_W-1:0]  len_i,
  input  logic [kcl_pkg::CODE_W-1:0] entry_i,
  input  logic [kcl_pkg::LEN_W-1:0]  count_i,
  output logic                       match_o
);
  import kcl_pkg::*;

  localparam int unsigned NBYTES = CODE_W / CHAR_W;

  logic [CODE_W-1:0] mask;

  always_comb begin
    mask = '0;
    for (int b = 0; b < NBYTES; b++) begin
      if (LEN_W'(b) < len_i) begin
        mask[CHAR_W*b +: CHAR_W] = '1;
      end
    end
  end

  // Lengths above the entry size can never equal the count, so they never match.
  assign match_o = (len_i == count_i) && (((code_i ^ entry_i) & mask) == '0);

endmodule
`default_nettype wire

// ----- hw/rtl/kcl_otc_mem.sv -----
// One-time code table storage: one write port, one registered read port.
`default_nettype none
module kcl_otc_mem #(
  parameter  int unsigned DEPTH = kcl_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  kcl_pkg::otc_wr_t    wr_i,
  input  logic [IDX_W-1:0]    wr_addr_i,
  input  logic [IDX_W-1:0]    rd_addr_i,
  output kcl_pkg::otc_entry_t rd_data_o
);
  import kcl_pkg::*;

  otc_entry_t otc_mem_q [DEPTH];
  otc_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      otc_mem_q[wr_addr_i] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= otc_mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ----- hw/rtl/keypad_code_lock_top.sv -----
// Keypad code lock: entry buffer, lock state and one-time code table scan.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+--------------------------------------------------
//  s_axis  | in  | s_axis_tvalid/tready  | tdata key, load_code, load_length; tuser req_type
//  m_axis  | out | m_axis_tvalid/tready  | tdata echo_valid .. codes_left
//  apb     | in  | psel, penable, pwrite | 0x0 master_code, 0x8 master_length
//
// A key item passes APPLY, CHECK and RESP when the master code or the lock entry
// decides it, and SCAN between CHECK and RESP when the table is scanned, one entry per
// cycle through the single compare unit and the table's read port.
// A load item passes FREE, one slot checked per cycle, and then RESP.
// The result waits in an output register; the next item is taken meanwhile.
// A stalled result holds only the final step. Reset clears lock, entry and
// table valid bits at once; no clearing pass.
`default_nettype none
module keypad_code_lock_top #(
  parameter int unsigned ENTRY_LEN   = kcl_pkg::ENTRY_LEN_DEF,
  parameter int unsigned TABLE_DEPTH = kcl_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input item
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] key, [71:8] load_code, [75:72] load_length, [79:76] zero
  input  logic [79:0] s_axis_tdata,
  // [0] req_type
  input  logic        s_axis_tuser,
  // Result item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] echo_valid, [8:1] echo_char, [9] clear_before, [12:10] event_res,
  // [13] lock_state, [18:14] codes_left, [23:19] zero
  output logic [23:0] m_axis_tdata,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import kcl_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [LEN_W-1:0] ENTRY_MAX = LEN_W'(ENTRY_LEN);
  localparam int unsigned NBYTES = CODE_W / CHAR_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_APPLY = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_FREE  = 6'b010000,
    ST_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [CODE_W-1:0] master_code_q;
  logic [LEN_W-1:0]  master_len_q;

  // Lock state
  logic              locked_q, locked_d;
  logic [CODE_W-1:0] entry_q, entry_d;
  logic [LEN_W-1:0]  count_q, count_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  idx_q, idx_d;

  // Latched input item
  logic [CHAR_W-1:0] key_q;
  logic [CODE_W-1:0] lcode_q;
  logic [LEN_W-1:0]  llen_q;

  // Result under construction
  logic              echo_q, echo_d;
  logic [CHAR_W-1:0] echo_char_q, echo_char_d;
  logic              clear_q, clear_d;
  event_e            event_q, event_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [23:0]       out_data_q, out_data_d;

  // Table and compare unit
  otc_wr_t           wr;
  logic [IDX_W-1:0]  rd_addr;
  otc_entry_t        rd_data;
  logic [CODE_W-1:0] cmp_code;
  logic [LEN_W-1:0]  cmp_len;
  logic              cmp_match;
  logic              in_accept;
  logic              out_free;
  logic              idx_last;

  kcl_otc_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .wr_addr_i (idx_q),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  kcl_match u_match (
    .code_i  (cmp_code),
    .len_i   (cmp_len),
    .entry_i (entry_q),
    .count_i (count_q),
    .match_o (cmp_match)
  );

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign idx_last  = (idx_q == LAST_IDX);

  // The compare unit sees the master or lock code first, then table entries.
  always_comb begin
    if (state_q == ST_SCAN) begin
      cmp_code = rd_data.code;
      cmp_len  = rd_data.len;
    end else if (locked_q) begin
      cmp_code = master_code_q;
      cmp_len  = master_len_q;
    end else begin
      cmp_code = STAR_CODE;
      cmp_len  = STAR_LEN;
    end
  end

  // Read one entry ahead so that each scan cycle finds its data registered.
  assign rd_addr = (state_q == ST_SCAN && !idx_last) ? idx_q + IDX_W'(1) : '0;

  assign wr.en        = (state_q == ST_FREE) && !valid_q[idx_q];
  assign wr.data.code = lcode_q;
  assign wr.data.len  = llen_q;

  always_comb begin
    state_d     = state_q;
    locked_d    = locked_q;
    entry_d     = entry_q;
    count_d     = count_q;
    valid_d     = valid_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    echo_d      = echo_q;
    echo_char_d = echo_char_q;
    clear_d     = clear_q;
    event_d     = event_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          echo_d      = 1'b0;
          echo_char_d = '0;
          clear_d     = 1'b0;
          event_d     = EV_NONE;
          idx_d       = '0;
          state_d     = (s_axis_tuser == REQ_LOAD) ? ST_FREE : ST_APPLY;
        end
      end
      ST_APPLY: begin
        clear_d = (count_q == '0);
        if (count_q < ENTRY_MAX) begin
          echo_d      = 1'b1;
          echo_char_d = key_q;
          count_d     = count_q + LEN_W'(1);
          for (int b = 0; b < NBYTES; b++) begin
            if (count_q == LEN_W'(b)) begin
              entry_d[CHAR_W*b +: CHAR_W] = key_q;
            end
          end
        end
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (cmp_match) begin
          locked_d = !locked_q;
          entry_d  = '0;
          count_d  = '0;
          event_d  = locked_q ? EV_MASTER : EV_LOCKED;
          state_d  = ST_RESP;
        end else if (locked_q) begin
          idx_d   = '0;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (valid_q[idx_q] && cmp_match) begin
          valid_d[idx_q] = 1'b0;
          cnt_d          = cnt_q - CNT_W'(1);
          locked_d       = 1'b0;
          entry_d        = '0;
          count_d        = '0;
          event_d        = EV_ONETIME;
          state_d        = ST_RESP;
        end else if (idx_last) begin
          state_d = ST_RESP;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_FREE: begin
        if (!valid_q[idx_q]) begin
          valid_d[idx_q] = 1'b1;
          cnt_d          = cnt_q + CNT_W'(1);
          event_d        = EV_STORED;
          state_d        = ST_RESP;
        end else if (idx_last) begin
          event_d = EV_FULL;
          state_d = ST_RESP;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {5'b0, 5'(cnt_q), locked_q, event_q, clear_q, echo_char_q, echo_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      locked_q      <= 1'b0;
      entry_q       <= '0;
      count_q       <= '0;
      valid_q       <= '0;
      cnt_q         <= '0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
      master_code_q <= MASTER_CODE_RESET;
      master_len_q  <= MASTER_LEN_RESET;
    end else begin
      state_q     <= state_d;
      locked_q    <= locked_d;
      entry_q     <= entry_d;
      count_q     <= count_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite) begin
        unique case (paddr[3])
          REG_MASTER_CODE: master_code_q <= pwdata;
          REG_MASTER_LEN:  master_len_q  <= pwdata[LEN_W-1:0];
          default:         master_len_q  <= master_len_q;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    echo_q      <= echo_d;
    echo_char_q <= echo_char_d;
    clear_q     <= clear_d;
    event_q     <= event_d;
    out_data_q  <= out_data_d;
    if (in_accept) begin
      key_q   <= s_axis_tdata[7:0];
      lcode_q <= s_axis_tdata[71:8];
      llen_q  <= s_axis_tdata[75:72];
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign pready        = 1'b1;
  assign prdata        = (paddr[3] == REG_MASTER_LEN) ? {60'b0, master_len_q} : master_code_q;

endmodule
`default_nettype wire

// ----- hw/rtl/kcl_checker.sv -----
// Port-level checks of the keypad code lock, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module kcl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  import kcl_pkg::*;

  logic       out_echo;
  logic [7:0] out_char;
  logic       out_clear;
  logic       out_lock;
  logic [2:0] out_event;
  logic       in_accept;
  logic       out_stall;
  logic       lock_event;
  logic       lock_match;
  logic       load_event;

  assign out_echo   = m_axis_tdata[0];
  assign out_char   = m_axis_tdata[8:1];
  assign out_clear  = m_axis_tdata[9];
  assign out_event  = m_axis_tdata[12:10];
  assign out_lock   = m_axis_tdata[13];
  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign lock_event = m_axis_tvalid && ((out_event == EV_MASTER) ||
                      (out_event == EV_ONETIME) || (out_event == EV_LOCKED));
  assign lock_match = (out_lock == (out_event == EV_LOCKED));
  assign load_event = m_axis_tvalid && ((out_event == EV_STORED) || (out_event == EV_FULL));

  // An accepted item makes the block busy, so ready drops once the item is taken.
  `ASSERT_CLK(a_busy_after_accept, clk_i, rst_ni, in_accept |=> !s_axis_tready)

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_stall |=> (m_axis_tvalid && $stable(m_axis_tdata)))

  // Unlock events leave the lock open, the lock event closes it.
  `ASSERT_IMPLIES(a_unlock_state, clk_i, rst_ni, lock_event, lock_match)

  // Table loads never touch the entry, so nothing is echoed or cleared.
  `ASSERT_IMPLIES(a_load_quiet, clk_i, rst_ni, load_event, !out_echo && !out_clear)

  `ASSERT_IMPLIES(a_echo_zero, clk_i, rst_ni, m_axis_tvalid && !out_echo, out_char == 8'd0)

endmodule

bind keypad_code_lock_top kcl_checker u_kcl_checker (.*);
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the keypad code lock: stream items in, results checked in order.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kcl_pkg::*;

  localparam int unsigned ENTRY_LEN     = ENTRY_LEN_DEF;
  localparam int unsigned TABLE_DEPTH   = TABLE_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS  = 1750;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned STALL_LIMIT   = 2000;

  localparam logic [3:0] ADDR_MASTER_CODE = {REG_MASTER_CODE, 3'b000};
  localparam logic [3:0] ADDR_MASTER_LEN  = {REG_MASTER_LEN, 3'b000};

  typedef struct packed {
    logic        req;
    logic [7:0]  key;
    logic [63:0] code;
    logic [3:0]  len;
  } lock_item_t;

  typedef struct packed {
    logic [4:0] codes_left;
    logic       lock_state;
    event_e     ev;
    logic       clear_before;
    logic [7:0] echo_char;
    logic       echo_valid;
  } lock_result_t;

  // Tracks the lock, the entry buffer and the one-time code table, and keeps the
  // results still owed by the block.
  class lock_checker;
    logic [63:0]  master_code;
    logic [3:0]   master_len;
    bit           locked;
    logic [63:0]  entry;
    int unsigned  entry_cnt;
    logic [63:0]  otc_code [TABLE_DEPTH];
    logic [3:0]   otc_len [TABLE_DEPTH];
    bit           otc_valid [TABLE_DEPTH];
    lock_result_t owed_results [$];
    int unsigned  errors;
    int unsigned  results_checked;
    int unsigned  ignored_keys;
    int unsigned  events_seen [6];

    function new();
      master_code = MASTER_CODE_RESET;
      master_len  = MASTER_LEN_RESET;
      locked      = 1'b0;
      entry       = '0;
      entry_cnt   = 0;
      foreach (otc_valid[i]) otc_valid[i] = 1'b0;
      foreach (events_seen[i]) events_seen[i] = 0;
      errors = 0;
      results_checked = 0;
      ignored_keys = 0;
    endfunction

    function void set_register(logic idx, logic [63:0] value);
      if (idx == REG_MASTER_CODE) begin
        master_code = value;
      end else begin
        master_len = value[3:0];
      end
    endfunction

    function bit entry_equals(logic [63:0] chars, logic [3:0] len);
      logic [63:0] mask;
      if (len != entry_cnt) return 1'b0;
      mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
      return ((chars ^ entry) & mask) == '0;
    endfunction

    function int free_slot();
      for (int i = 0; i < TABLE_DEPTH; i++) if (!otc_valid[i]) return i;
      return -1;
    endfunction

    function int unsigned valid_codes();
      int unsigned n;
      n = 0;
      foreach (otc_valid[i]) if (otc_valid[i]) n++;
      return n;
    endfunction

    // Codes that can never match and so hold their slot for good.
    function int unsigned dead_codes();
      int unsigned n;
      n = 0;
      foreach (otc_valid[i])
        if (otc_valid[i] && (otc_len[i] == 0 || otc_len[i] > ENTRY_LEN)) n++;
      return n;
    endfunction

    function void take_item(lock_item_t it);
      lock_result_t r;
      int slot;
      r = '0;
      r.ev = EV_NONE;
      if (it.req == REQ_LOAD) begin
        r.ev = EV_FULL;
        slot = free_slot();
        if (slot >= 0) begin
          otc_code[slot]  = it.code;
          otc_len[slot]   = it.len;
          otc_valid[slot] = 1'b1;
          r.ev = EV_STORED;
        end
      end else begin
        r.clear_before = (entry_cnt == 0);
        if (entry_cnt < ENTRY_LEN) begin
          r.echo_valid = 1'b1;
          r.echo_char  = it.key;
          entry[8*entry_cnt +: 8] = it.key;
          entry_cnt++;
        end else begin
          ignored_keys++;
        end
        if (locked) begin
          if (entry_equals(master_code, master_len)) begin
            r.ev = EV_MASTER;
          end else begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (otc_valid[i] && entry_equals(otc_code[i], otc_len[i])) begin
                otc_valid[i] = 1'b0;
                r.ev = EV_ONETIME;
                break;
              end
            end
          end
          if (r.ev != EV_NONE) locked = 1'b0;
        end else if (entry_equals(STAR_CODE, STAR_LEN)) begin
          locked = 1'b1;
          r.ev = EV_LOCKED;
        end
        if (r.ev != EV_NONE) begin
          entry = '0;
          entry_cnt = 0;
        end
      end
      r.lock_state = locked;
      r.codes_left = 5'(valid_codes());
      events_seen[r.ev]++;
      owed_results = {owed_results, r};
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [23:0] data);
      lock_result_t got, want;
      got = lock_result_t'(data[18:0]);
      if (owed_results.size() == 0) begin
        $error("result item %h arrived with nothing expected", data);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("echo_valid", want.echo_valid, got.echo_valid);
      compare_field("echo_char", want.echo_char, got.echo_char);
      compare_field("clear_before", want.clear_before, got.clear_before);
      compare_field("event_res", want.ev, got.ev);
      compare_field("lock_state", want.lock_state, got.lock_state);
      compare_field("codes_left", want.codes_left, got.codes_left);
      compare_field("tdata padding", '0, data[23:19]);
      results_checked++;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  keypad_code_lock_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  lock_checker sb = new();

  lock_item_t  item_plan [$];
  bit          plan_locked;
  int unsigned src_idle_pct = 25;
  int unsigned sink_idle_pct = 25;
  int unsigned items_sent = 0;
  int unsigned loads_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned stalled_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    wait (stalled_cycles >= STALL_LIMIT);
    $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stall bursts, none when the percentage is zero.
  initial begin
    m_axis_tready <= 1'b1;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] rand_char();
    if ($urandom_range(0, 1) == 1) return 8'(8'h30 + $urandom_range(0, 3));
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [63:0] rand_code();
    logic [63:0] c;
    for (int i = 0; i < 8; i++) c[8*i +: 8] = rand_char();
    return c;
  endfunction

  function automatic lock_item_t key_item(logic [7:0] key);
    lock_item_t it;
    it.req  = REQ_KEY;
    it.key  = key;
    it.code = {$urandom, $urandom};
    it.len  = 4'($urandom_range(0, 15));
    return it;
  endfunction

  function automatic lock_item_t load_item(logic [63:0] code, logic [3:0] len);
    lock_item_t it;
    it.req  = REQ_LOAD;
    it.key  = 8'($urandom_range(0, 255));
    it.code = code;
    it.len  = len;
    return it;
  endfunction

  // Appends one item to the end of the plan.
  function automatic void plan_item(lock_item_t it);
    item_plan = {item_plan, it};
  endfunction

  function automatic void plan_chars(logic [63:0] chars, int unsigned n);
    for (int i = 0; i < n; i++) plan_item(key_item(chars[8*i +: 8]));
  endfunction

  // A code can be typed when its length fits the entry and no character is zero.
  function automatic bit typeable(logic [63:0] chars, logic [3:0] len);
    if (len == 0 || len > ENTRY_LEN) return 1'b0;
    for (int i = 0; i < len; i++) if (chars[8*i +: 8] == 8'd0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 50;
    endcase
  endfunction

  task automatic send_item(lock_item_t it);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.req;
    s_axis_tdata  <= {4'd0, it.len, it.code, it.key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_item(it);
    items_sent++;
    if (it.req == REQ_LOAD) loads_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [3:0] addr, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_register(addr[3], value);
    reg_writes++;
    // Read the register back; psel stays high into the next setup phase.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr[3] == REG_MASTER_LEN) begin
      sb.compare_field("prdata master_length", 64'(sb.master_len), 64'(prdata[3:0]));
    end else begin
      sb.compare_field("prdata master_code", sb.master_code, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Plans the next key sequence from the current lock state. While unlocked only
  // stars are typed, since any other key would leave the entry stuck for good.
  task automatic make_plan();
    logic [63:0] chars;
    int unsigned n;
    int unsigned pos;
    int unsigned pick;
    int unsigned cands [$];
    plan_locked = sb.locked;
    if (!sb.locked) begin
      plan_chars(STAR_CODE, STAR_LEN - sb.entry_cnt);
    end else if (sb.entry_cnt >= ENTRY_LEN) begin
      if ($urandom_range(0, 1) == 1) begin
        plan_item(key_item(rand_char()));
      end else begin
        // A full entry only clears on a match, so supply a code equal to it.
        if (sb.free_slot() < 0) begin
          drain_results();
          write_register(ADDR_MASTER_CODE, sb.entry);
          write_register(ADDR_MASTER_LEN, 64'(ENTRY_LEN));
        end else begin
          plan_item(load_item(sb.entry, 4'(ENTRY_LEN)));
        end
        plan_item(key_item(rand_char()));
      end
    end else if (sb.entry_cnt > 0) begin
      repeat (ENTRY_LEN - sb.entry_cnt) plan_item(key_item(rand_char()));
    end else begin
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (sb.otc_valid[i] && typeable(sb.otc_code[i], sb.otc_len[i])) cands = {cands, i};
      pick = $urandom_range(0, 9);
      if (pick < 3 && typeable(sb.master_code, sb.master_len)) begin
        chars = sb.master_code;
        n = sb.master_len;
      end else if (pick < 7 && cands.size() != 0) begin
        pos = cands[$urandom_range(0, cands.size() - 1)];
        chars = sb.otc_code[pos];
        n = sb.otc_len[pos];
      end else begin
        chars = rand_code();
        n = $urandom_range(1, ENTRY_LEN);
      end
      if ($urandom_range(0, 4) == 0) begin
        pos = $urandom_range(0, n - 1);
        chars[8*pos +: 8] = rand_char();
      end
      plan_chars(chars, n);
    end
  endtask

  task automatic random_step();
    lock_item_t it;
    int unsigned load_pct;
    load_pct = (sb.free_slot() >= 0) ? 15 : 4;
    if ($urandom_range(0, 99) < load_pct) begin
      it = load_item(rand_code(), 4'($urandom_range(1, ENTRY_LEN)));
      if (sb.dead_codes() < 4 && $urandom_range(0, 39) == 0)
        it.len = ($urandom_range(0, 1) == 1) ? 4'd0 : 4'($urandom_range(ENTRY_LEN + 1, 15));
    end else begin
      if (item_plan.size() == 0 || plan_locked != sb.locked) begin
        item_plan.delete();
        make_plan();
      end
      it = item_plan.pop_front();
    end
    send_item(it);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a short code with junk above its length, an empty code, an
    // over-long code and one holding a zero character; then lock and open with
    // the reset master code, with the short code and with the zero-character code.
    plan_item(load_item(64'hFFFF_FFFF_FFFF_3231, 4'd2));
    plan_item(load_item(64'd0, 4'd0));
    plan_item(load_item('1, 4'd15));
    plan_item(load_item(64'h0041, 4'd2));
    plan_chars(STAR_CODE, STAR_LEN);
    plan_chars(MASTER_CODE_RESET, 8);
    plan_chars(STAR_CODE, STAR_LEN);
    plan_chars(64'h3231, 2);
    plan_chars(STAR_CODE, STAR_LEN);
    plan_chars(64'h0041, 2);
    while (item_plan.size() != 0) send_item(item_plan.pop_front());

    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: begin
          write_register(ADDR_MASTER_CODE, '1);
          write_register(ADDR_MASTER_LEN, 64'd8);
        end
        1: begin
          write_register(ADDR_MASTER_CODE, '0);
          write_register(ADDR_MASTER_LEN, 64'd0);
        end
        2: begin
          write_register(ADDR_MASTER_CODE, rand_code());
          write_register(ADDR_MASTER_LEN, 64'd15);
        end
        default: begin
          write_register(ADDR_MASTER_CODE, rand_code());
          write_register(ADDR_MASTER_LEN, 64'($urandom_range(1, ENTRY_LEN)));
        end
      endcase
      item_plan.delete();
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        if (n % 64 == 0) begin
          src_idle_pct  = (phase == 3) ? 0 : pick_idle_pct();
          sink_idle_pct = (phase == 3) ? 0 : pick_idle_pct();
        end
        random_step();
      end
    end

    drain_results();
    $display("Sent %0d items (%0d code loads), checked %0d results, wrote %0d registers.",
             items_sent, loads_sent, sb.results_checked, reg_writes);
    $display("Seen: %0d master and %0d one-time unlocks, %0d locks, %0d stores,",
             sb.events_seen[EV_MASTER], sb.events_seen[EV_ONETIME],
             sb.events_seen[EV_LOCKED], sb.events_seen[EV_STORED]);
    $display("      %0d refused loads, %0d keys on a full entry.",
             sb.events_seen[EV_FULL], sb.ignored_keys);
    if (sb.errors == 0 && sb.owed_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/kcl_pkg.sv
hw/rtl/kcl_match.sv
hw/rtl/kcl_otc_mem.sv
hw/rtl/keypad_code_lock_top.sv
hw/rtl/kcl_checker.sv
verif/tb.sv
